>>> sv/stt_pkg.sv
// Shared types, character codes and keyword table for the source text tokenizer.
`default_nettype none

package stt_pkg;

	localparam int COUNTER_BITS_DEFAULT = 16;
	localparam int KW_NUM = 7;
	localparam int KW_MAX_LEN = 7;

	localparam logic [3:0] K_KEYWORD = 4'd0;
	localparam logic [3:0] K_IDENT = 4'd1;
	localparam logic [3:0] K_NUMBER = 4'd2;
	localparam logic [3:0] K_STRING = 4'd3;
	localparam logic [3:0] K_EQUAL = 4'd4;
	localparam logic [3:0] K_LBRACE = 4'd5;
	localparam logic [3:0] K_RBRACE = 4'd6;
	localparam logic [3:0] K_OPERATOR = 4'd7;
	localparam logic [3:0] K_UNKNOWN = 4'd8;
	localparam logic [3:0] K_UNTERM = 4'd9;

	localparam logic [2:0] NO_KEYWORD = 3'd7;

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Keyword spellings, unused tail bytes are zero.
	localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
		'{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h73, 8'h63, 8'h65, 8'h6E, 8'h65, 8'h00, 8'h00},
		'{8'h73, 8'h68, 8'h61, 8'h64, 8'h65, 8'h72, 8'h00},
		'{8'h61, 8'h6E, 8'h69, 8'h6D, 8'h61, 8'h74, 8'h65},
		'{8'h66, 8'h72, 8'h6F, 8'h6D, 8'h00, 8'h00, 8'h00},
		'{8'h74, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h65, 8'h61, 8'h73, 8'h69, 8'h6E, 8'h67, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd5, 3'd6, 3'd7, 3'd4, 3'd2, 3'd6};

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  kw;
		logic [7:0]  ch;
		logic [15:0] len;
		logic [15:0] line;
		logic [15:0] col;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

`default_nettype wire

>>> sv/source_text_tokenizer.sv
// Top level of the source text tokenizer: input stage, scanner logic and result bank.
`default_nettype none

// Usage:
// Source bytes enter on the slave stream, one byte per item in s_tdata, with
// s_tlast marking the last byte of a source text. Tokens leave on the master
// stream, one token per item; m_tlast marks the last token caused by one byte.
// A byte is registered in the input stage on the edge it is accepted; its
// tokens are written to the result bank once the bank is free and are offered
// from then. Text that yields at most one token per byte streams at one byte
// per cycle while the receiver takes every token. A byte that causes several
// tokens keeps the bank busy until they have all left, and a following byte
// that causes tokens waits in the input stage until the last of them leaves.
// When the receiver stalls, the bank holds its token, the input stage fills
// and s_tready falls; nothing is dropped.
// A byte with s_tlast flushes any pending token and returns the scanner to its
// reset state. Reset clears the stages, the bank and the scanner at once;
// there is no clearing pass. Counters are COUNTER_BITS wide and saturate,
// reported fields saturate at 65535.
module source_text_tokenizer #(
	parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_final
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [3:0] token_kind, [6:4] keyword_index, [14:7] token_char, [30:15] token_length,
	// [46:31] line_number, [62:47] column_number, [63] zero
	output logic [63:0]      m_tdata,
	output logic             m_tlast    // last_of_run
);
	import stt_pkg::*;

	localparam int CB = COUNTER_BITS;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_IDENT = 3'd1;
	localparam logic [2:0] M_INT = 3'd2;
	localparam logic [2:0] M_DOT = 3'd3;
	localparam logic [2:0] M_FRAC = 3'd4;
	localparam logic [2:0] M_STRING = 3'd5;
	localparam logic [2:0] M_SLASH = 3'd6;
	localparam logic [2:0] M_COMMENT = 3'd7;

	localparam logic [CB-1:0] CNT_ONE = CB'(1);
	localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

	function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic logic [15:0] clamp16(input logic [CB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic token_t mk_tok(input logic [3:0] kind, input logic [2:0] kw,
			input logic [7:0] ch, input logic [CB-1:0] len, input logic [CB-1:0] line,
			input logic [CB-1:0] col);
		token_t t;
		t.kind = kind;
		t.kw = kw;
		t.ch = ch;
		t.len = clamp16(len);
		t.line = clamp16(line);
		t.col = clamp16(col);
		return t;
	endfunction

	// Drops every keyword that ends before position p or whose character at position p differs from c.
	function automatic logic [KW_NUM-1:0] filter_kw(input logic [KW_NUM-1:0] cand,
			input logic [7:0] c, input logic [CB-1:0] p);
		logic [KW_NUM-1:0] r;
		r = cand;
		for (int k = 0; k < KW_NUM; k++) begin
			if (p >= CB'(KW_LEN[k])) begin
				r[k] = 1'b0;
			end else if (KW_TEXT[k][p[2:0]] != c) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic token_t word_tok(input logic [KW_NUM-1:0] cand,
			input logic [CB-1:0] len, input logic [7:0] ch, input logic [CB-1:0] line,
			input logic [CB-1:0] col);
		logic found;
		logic [2:0] idx;
		found = 1'b0;
		idx = NO_KEYWORD;
		for (int k = 0; k < KW_NUM; k++) begin
			if (!found && cand[k] && (len == CB'(KW_LEN[k]))) begin
				found = 1'b1;
				idx = 3'(k);
			end
		end
		return mk_tok(found ? K_KEYWORD : K_IDENT, idx, ch, len, line, col);
	endfunction

	// Input stage.
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        fin_s1;
	logic        adv_s1;

	// Scanner state.
	logic [2:0]        mode_q, mode_d;
	logic [CB-1:0]     len_q, len_d;
	logic [KW_NUM-1:0] cand_q, cand_d;
	logic [CB-1:0]     line_q, line_d;
	logic [CB-1:0]     col_q, col_d;
	logic [CB-1:0]     lcl_q, lcl_d;
	logic [CB-1:0]     lcc_q, lcc_d;
	logic [7:0]        lcch_q, lcch_d;

	// Result bank.
	token_t      bank_q [3];
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;
	logic        pop;
	logic        last_out;
	logic        bank_free;

	token_t      toks [3];
	logic [1:0]  tok_n;

	always_comb begin
		logic [7:0]    c;
		logic [CB-1:0] pos_line;
		logic [CB-1:0] pos_col;
		logic          rescan;
		token_t        cand_tok [5];
		logic [4:0]    cand_v;

		c = char_s1;
		pos_line = line_q;
		pos_col = sat_inc(col_q);
		rescan = 1'b0;
		cand_v = '0;
		for (int i = 0; i < 5; i++) begin
			cand_tok[i] = '0;
		end

		mode_d = mode_q;
		len_d = len_q;
		cand_d = cand_q;
		lcch_d = lcch_q;
		lcl_d = lcl_q;
		lcc_d = lcc_q;

		// Close or extend the token in progress.
		case (mode_q)
			M_IDENT: begin
				if (is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE)) begin
					cand_d = filter_kw(cand_q, c, len_q);
					len_d = sat_inc(len_q);
					lcch_d = c;
					lcl_d = pos_line;
					lcc_d = pos_col;
				end else begin
					cand_v[0] = 1'b1;
					cand_tok[0] = word_tok(cand_q, len_q, lcch_q, lcl_q, lcc_q);
					rescan = 1'b1;
				end
			end
			M_INT, M_FRAC: begin
				if (is_digit(c)) begin
					len_d = sat_inc(len_q);
					lcch_d = c;
					lcl_d = pos_line;
					lcc_d = pos_col;
				end else if ((mode_q == M_INT) && (c == CH_DOT)) begin
					mode_d = M_DOT;
				end else begin
					cand_v[0] = 1'b1;
					cand_tok[0] = mk_tok(K_NUMBER, NO_KEYWORD, lcch_q, len_q, lcl_q, lcc_q);
					rescan = 1'b1;
				end
			end
			M_DOT: begin
				if (is_digit(c)) begin
					// The held dot and the new digit both join the number.
					len_d = sat_inc(sat_inc(len_q));
					lcch_d = c;
					lcl_d = pos_line;
					lcc_d = pos_col;
					mode_d = M_FRAC;
				end else begin
					cand_v[0] = 1'b1;
					cand_tok[0] = mk_tok(K_NUMBER, NO_KEYWORD, lcch_q, len_q, lcl_q, lcc_q);
					cand_v[1] = 1'b1;
					cand_tok[1] = mk_tok(K_UNKNOWN, NO_KEYWORD, CH_DOT, CNT_ONE, line_q, col_q);
					rescan = 1'b1;
				end
			end
			M_STRING: begin
				len_d = sat_inc(len_q);
				lcch_d = c;
				lcl_d = pos_line;
				lcc_d = pos_col;
				if (c == CH_QUOTE) begin
					cand_v[0] = 1'b1;
					cand_tok[0] = mk_tok(K_STRING, NO_KEYWORD, c, sat_inc(len_q), pos_line,
						pos_col);
					mode_d = M_IDLE;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d = M_COMMENT;
				end else begin
					cand_v[0] = 1'b1;
					cand_tok[0] = mk_tok(K_OPERATOR, NO_KEYWORD, lcch_q, len_q, lcl_q, lcc_q);
					rescan = 1'b1;
				end
			end
			M_COMMENT: begin
				rescan = (c == CH_LF);
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		// Scan the byte afresh from the idle state.
		if (rescan) begin
			mode_d = M_IDLE;
			if (is_digit(c) || is_alpha(c) || (c == CH_QUOTE) || (c == CH_SLASH)) begin
				len_d = CNT_ONE;
				lcch_d = c;
				lcl_d = pos_line;
				lcc_d = pos_col;
				if (is_digit(c)) begin
					mode_d = M_INT;
				end else if (is_alpha(c)) begin
					mode_d = M_IDENT;
					cand_d = filter_kw({KW_NUM{1'b1}}, c, '0);
				end else if (c == CH_QUOTE) begin
					mode_d = M_STRING;
				end else begin
					mode_d = M_SLASH;
				end
			end else if (!is_space(c)) begin
				cand_v[2] = 1'b1;
				if (c == CH_EQUAL) begin
					cand_tok[2] = mk_tok(K_EQUAL, NO_KEYWORD, c, CNT_ONE, pos_line, pos_col);
				end else if (c == CH_LBRACE) begin
					cand_tok[2] = mk_tok(K_LBRACE, NO_KEYWORD, c, CNT_ONE, pos_line, pos_col);
				end else if (c == CH_RBRACE) begin
					cand_tok[2] = mk_tok(K_RBRACE, NO_KEYWORD, c, CNT_ONE, pos_line, pos_col);
				end else if ((c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR)) begin
					cand_tok[2] = mk_tok(K_OPERATOR, NO_KEYWORD, c, CNT_ONE, pos_line, pos_col);
				end else begin
					cand_tok[2] = mk_tok(K_UNKNOWN, NO_KEYWORD, c, CNT_ONE, pos_line, pos_col);
				end
			end
		end

		if (c == CH_LF) begin
			line_d = sat_inc(line_q);
			col_d = '0;
		end else begin
			line_d = line_q;
			col_d = pos_col;
		end

		// The last byte flushes what is still open, then everything resets.
		if (fin_s1) begin
			case (mode_d)
				M_IDENT: begin
					cand_v[3] = 1'b1;
					cand_tok[3] = word_tok(cand_d, len_d, lcch_d, lcl_d, lcc_d);
				end
				M_INT, M_FRAC: begin
					cand_v[3] = 1'b1;
					cand_tok[3] = mk_tok(K_NUMBER, NO_KEYWORD, lcch_d, len_d, lcl_d, lcc_d);
				end
				M_DOT: begin
					cand_v[3] = 1'b1;
					cand_tok[3] = mk_tok(K_NUMBER, NO_KEYWORD, lcch_d, len_d, lcl_d, lcc_d);
					cand_v[4] = 1'b1;
					cand_tok[4] = mk_tok(K_UNKNOWN, NO_KEYWORD, CH_DOT, CNT_ONE, line_d, col_d);
				end
				M_STRING: begin
					cand_v[3] = 1'b1;
					cand_tok[3] = mk_tok(K_UNTERM, NO_KEYWORD, lcch_d, len_d, lcl_d, lcc_d);
				end
				M_SLASH: begin
					cand_v[3] = 1'b1;
					cand_tok[3] = mk_tok(K_OPERATOR, NO_KEYWORD, lcch_d, len_d, lcl_d, lcc_d);
				end
				default: begin
				end
			endcase
			mode_d = M_IDLE;
			len_d = '0;
			cand_d = {KW_NUM{1'b1}};
			line_d = CNT_ONE;
			col_d = '0;
			lcl_d = CNT_ONE;
			lcc_d = '0;
			lcch_d = '0;
		end

		// At most three of the five candidates are ever valid together.
		tok_n = '0;
		for (int i = 0; i < 3; i++) begin
			toks[i] = '0;
		end
		for (int i = 0; i < 5; i++) begin
			if (cand_v[i] && (tok_n != 2'd3)) begin
				toks[tok_n] = cand_tok[i];
				tok_n = tok_n + 2'd1;
			end
		end
	end

	assign pop = m_tvalid && m_tready;
	assign last_out = (idx_q == (cnt_q - 2'd1));
	assign bank_free = (cnt_q == 2'd0) || (pop && last_out);
	assign adv_s1 = valid_s1 && ((tok_n == 2'd0) || bank_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			fin_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q <= '0;
			cand_q <= {KW_NUM{1'b1}};
			line_q <= CNT_ONE;
			col_q <= '0;
			lcl_q <= CNT_ONE;
			lcc_q <= '0;
			lcch_q <= '0;
		end else if (adv_s1) begin
			mode_q <= mode_d;
			len_q <= len_d;
			cand_q <= cand_d;
			line_q <= line_d;
			col_q <= col_d;
			lcl_q <= lcl_d;
			lcc_q <= lcc_d;
			lcch_q <= lcch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (adv_s1 && (tok_n != 2'd0)) begin
			cnt_q <= tok_n;
			idx_q <= '0;
		end else if (pop) begin
			if (last_out) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (tok_n != 2'd0)) begin
			for (int i = 0; i < 3; i++) begin
				bank_q[i] <= toks[i];
			end
		end
	end

	token_t out_tok;
	assign out_tok = bank_q[idx_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tlast = last_out;
	assign m_tdata = {1'b0, out_tok.col, out_tok.line, out_tok.len, out_tok.ch, out_tok.kw,
		out_tok.kind};

`ifndef SYNTHESIS
	a_idx_in_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> (idx_q < cnt_q))
		else $error("result index beyond bank fill");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && fin_s1) |=> ((mode_q == M_IDLE) && (line_q == CNT_ONE) &&
			(col_q == '0) && (len_q == '0)))
		else $error("scanner not back at reset state after final byte");

	a_bank_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && last_out) |=> ((cnt_q == 2'd0) || (idx_q == 2'd0)))
		else $error("bank not emptied or reloaded after its last token");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != '0) && (lcl_q != '0))
		else $error("line counter reached zero");
`endif

endmodule

`default_nettype wire

>>> bench/tb_source_text_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the source text tokenizer with a token scoreboard and stream drivers.
module tb_source_text_tokenizer;
	import stt_pkg::*;

	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_BYTES = 180;
	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	source_text_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	class token_scoreboard;
		typedef enum {
			SCAN_IDLE, SCAN_WORD, SCAN_INT, SCAN_DOT,
			SCAN_FRAC, SCAN_STRING, SCAN_SLASH, SCAN_COMMENT
		} scan_e;

		typedef struct {
			token_t tok;
			logic   last;
		} expected_token_t;

		expected_token_t expected_tokens[$];
		expected_token_t step_tokens[$];
		int errors;
		int checked;

		scan_e       mode;
		logic [15:0] len_cnt;
		logic [6:0]  candidates;
		logic [15:0] line_cnt;
		logic [15:0] col_cnt;
		logic [15:0] tok_col;
		logic [15:0] tok_line;
		logic [7:0]  tok_ch;

		function new();
			errors = 0;
			checked = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode = SCAN_IDLE;
			len_cnt = 16'd0;
			candidates = 7'h7F;
			line_cnt = 16'd1;
			col_cnt = 16'd0;
			tok_col = 16'd0;
			tok_line = 16'd1;
			tok_ch = 8'h00;
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction

		function logic [15:0] sat_up(input logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function logic digit_c(input logic [7:0] c);
			return c inside {[8'h30 : 8'h39]};
		endfunction

		function logic letter_c(input logic [7:0] c);
			return (c inside {[8'h41 : 8'h5A]}) || (c inside {[8'h61 : 8'h7A]});
		endfunction

		function logic blank_c(input logic [7:0] c);
			return (c == CH_SPACE) || (c inside {[8'h09 : 8'h0D]});
		endfunction

		// At most three tokens leave per byte; anything beyond is dropped.
		function void put_token(input logic [3:0] kind, input logic [2:0] kw,
				input logic [7:0] ch, input logic [15:0] len,
				input logic [15:0] line, input logic [15:0] col);
			expected_token_t e;
			if (step_tokens.size() >= 3)
				return;
			e.tok.kind = kind;
			e.tok.kw = kw;
			e.tok.ch = ch;
			e.tok.len = len;
			e.tok.line = line;
			e.tok.col = col;
			e.last = 1'b0;
			step_tokens.insert(step_tokens.size(), e);
		endfunction

		function void filter(input logic [7:0] c, input logic [15:0] p);
			for (int k = 0; k < KW_NUM; k++) begin
				if (p >= 16'(KW_LEN[k]) || KW_TEXT[k][p[2:0]] != c)
					candidates[k] = 1'b0;
			end
		endfunction

		function void begin_tok(input scan_e m, input logic [7:0] c,
				input logic [15:0] line, input logic [15:0] col);
			mode = m;
			len_cnt = 16'd1;
			tok_ch = c;
			tok_line = line;
			tok_col = col;
		endfunction

		function void extend(input logic [7:0] c, input logic [15:0] line,
				input logic [15:0] col);
			len_cnt = sat_up(len_cnt);
			tok_ch = c;
			tok_line = line;
			tok_col = col;
		endfunction

		function void emit_open(input logic [3:0] kind, input logic [2:0] kw);
			put_token(kind, kw, tok_ch, len_cnt, tok_line, tok_col);
		endfunction

		function void emit_word();
			for (int k = 0; k < KW_NUM; k++) begin
				if (candidates[k] && len_cnt == 16'(KW_LEN[k])) begin
					emit_open(K_KEYWORD, 3'(k));
					return;
				end
			end
			emit_open(K_IDENT, NO_KEYWORD);
		endfunction

		function void scan_fresh(input logic [7:0] c, input logic [15:0] line,
				input logic [15:0] col);
			mode = SCAN_IDLE;
			if (digit_c(c)) begin
				begin_tok(SCAN_INT, c, line, col);
			end else if (letter_c(c)) begin
				begin_tok(SCAN_WORD, c, line, col);
				candidates = 7'h7F;
				filter(c, 16'd0);
			end else if (c == CH_EQUAL) begin
				put_token(K_EQUAL, NO_KEYWORD, c, 16'd1, line, col);
			end else if (c == CH_LBRACE) begin
				put_token(K_LBRACE, NO_KEYWORD, c, 16'd1, line, col);
			end else if (c == CH_RBRACE) begin
				put_token(K_RBRACE, NO_KEYWORD, c, 16'd1, line, col);
			end else if (c == CH_QUOTE) begin
				begin_tok(SCAN_STRING, c, line, col);
			end else if (c == CH_SLASH) begin
				begin_tok(SCAN_SLASH, c, line, col);
			end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR) begin
				put_token(K_OPERATOR, NO_KEYWORD, c, 16'd1, line, col);
			end else if (!blank_c(c)) begin
				put_token(K_UNKNOWN, NO_KEYWORD, c, 16'd1, line, col);
			end
		endfunction

		function void scan(input logic [7:0] c, input logic [15:0] line,
				input logic [15:0] col);
			case (mode)
				SCAN_WORD: begin
					if (letter_c(c) || digit_c(c) || c == CH_UNDERSCORE) begin
						filter(c, len_cnt);
						extend(c, line, col);
						return;
					end
					emit_word();
				end
				SCAN_INT: begin
					if (digit_c(c)) begin
						extend(c, line, col);
						return;
					end
					if (c == CH_DOT) begin
						mode = SCAN_DOT;
						return;
					end
					emit_open(K_NUMBER, NO_KEYWORD);
				end
				SCAN_DOT: begin
					// The held dot joins the number only when a digit follows.
					if (digit_c(c)) begin
						len_cnt = sat_up(len_cnt);
						extend(c, line, col);
						mode = SCAN_FRAC;
						return;
					end
					emit_open(K_NUMBER, NO_KEYWORD);
					put_token(K_UNKNOWN, NO_KEYWORD, CH_DOT, 16'd1, line_cnt, col_cnt);
				end
				SCAN_FRAC: begin
					if (digit_c(c)) begin
						extend(c, line, col);
						return;
					end
					emit_open(K_NUMBER, NO_KEYWORD);
				end
				SCAN_STRING: begin
					extend(c, line, col);
					if (c == CH_QUOTE) begin
						emit_open(K_STRING, NO_KEYWORD);
						mode = SCAN_IDLE;
					end
					return;
				end
				SCAN_SLASH: begin
					if (c == CH_SLASH) begin
						mode = SCAN_COMMENT;
						return;
					end
					emit_open(K_OPERATOR, NO_KEYWORD);
				end
				SCAN_COMMENT: begin
					if (c != CH_LF)
						return;
				end
				default: ;
			endcase
			scan_fresh(c, line, col);
		endfunction

		function void flush();
			case (mode)
				SCAN_WORD: emit_word();
				SCAN_INT, SCAN_FRAC: emit_open(K_NUMBER, NO_KEYWORD);
				SCAN_DOT: begin
					emit_open(K_NUMBER, NO_KEYWORD);
					put_token(K_UNKNOWN, NO_KEYWORD, CH_DOT, 16'd1, line_cnt, col_cnt);
				end
				SCAN_STRING: emit_open(K_UNTERM, NO_KEYWORD);
				SCAN_SLASH: emit_open(K_OPERATOR, NO_KEYWORD);
				default: ;
			endcase
		endfunction

		function void note_byte(input logic [7:0] c, input logic fin);
			logic [15:0] at_line;
			logic [15:0] at_col;
			at_line = line_cnt;
			at_col = sat_up(col_cnt);
			step_tokens.delete();
			scan(c, at_line, at_col);
			if (c == CH_LF) begin
				line_cnt = sat_up(line_cnt);
				col_cnt = 16'd0;
			end else begin
				col_cnt = at_col;
			end
			if (fin) begin
				flush();
				clear_state();
			end
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last = 1'b1;
			foreach (step_tokens[i])
				expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
		endfunction

		task flag_mismatch(input string what, input logic [63:0] got,
				input logic [63:0] want);
			$display("token %0d: %s is %0h, expected %0h", checked, what, got, want);
			errors++;
		endtask

		task check_token(input logic [63:0] data, input logic last);
			expected_token_t e;
			if (expected_tokens.size() == 0) begin
				flag_mismatch("token with nothing expected", data, 64'd0);
				checked++;
				return;
			end
			e = expected_tokens.pop_front();
			if (data[3:0] !== e.tok.kind)
				flag_mismatch("token_kind", data[3:0], e.tok.kind);
			if (data[6:4] !== e.tok.kw)
				flag_mismatch("keyword_index", data[6:4], e.tok.kw);
			if (data[14:7] !== e.tok.ch)
				flag_mismatch("token_char", data[14:7], e.tok.ch);
			if (data[30:15] !== e.tok.len)
				flag_mismatch("token_length", data[30:15], e.tok.len);
			if (data[46:31] !== e.tok.line)
				flag_mismatch("line_number", data[46:31], e.tok.line);
			if (data[62:47] !== e.tok.col)
				flag_mismatch("column_number", data[62:47], e.tok.col);
			if (data[63] !== 1'b0)
				flag_mismatch("pad bit", data[63], 1'b0);
			if (last !== e.last)
				flag_mismatch("last_of_run", last, e.last);
			checked++;
		endtask
	endclass

	token_scoreboard sb;
	logic [7:0] text_q[$];
	int burst_left = 4;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;

	function automatic void add_char(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_token(m_tdata, m_tlast);
		end
	end

	// Receiver: stretches of different stall styles, plus one long hold on request.
	initial begin : receiver
		int stretch;
		int style;
		int phase;
		logic [7:0] pattern;
		phase = 0;
		forever begin
			style = $urandom_range(0, 3);
			stretch = $urandom_range(8, 60);
			pattern = $urandom_range(1, 255);
			repeat (stretch) begin
				@(posedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				phase++;
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= pattern[phase % 8];
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		if (!no_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 6);
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Sends the collected bytes as one source text, the last byte marked final.
	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		return ($urandom_range(0, 3) == 0) ? c - 8'h20 : c;
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 4))
			0: return 8'h30 + 8'($urandom_range(0, 9));
			1: return CH_UNDERSCORE;
			default: return rand_letter();
		endcase
	endfunction

	function automatic void push_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			add_char(8'h30 + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void push_lexeme();
		int k;
		int n;
		logic [7:0] c;
		string punct;
		punct = "={}+-*/";
		case ($urandom_range(0, 11))
			0, 1: begin
				k = $urandom_range(0, KW_NUM - 1);
				for (int i = 0; i < KW_LEN[k]; i++)
					add_char(KW_TEXT[k][i]);
			end
			2: begin
				// Near misses of a keyword: a prefix or one character too many.
				k = $urandom_range(0, KW_NUM - 1);
				n = $urandom_range(0, 1) ? $urandom_range(1, KW_LEN[k] - 1) : KW_LEN[k];
				for (int i = 0; i < n; i++)
					add_char(KW_TEXT[k][i]);
				if (n == KW_LEN[k])
					add_char(rand_word_char());
			end
			3: begin
				add_char(rand_letter());
				repeat ($urandom_range(0, 7))
					add_char(rand_word_char());
			end
			4: push_digits(1, 5);
			5: begin
				push_digits(1, 3);
				add_char(CH_DOT);
				push_digits(1, 4);
			end
			6: begin
				push_digits(1, 3);
				add_char(CH_DOT);
				case ($urandom_range(0, 3))
					0: add_char(rand_letter());
					1: add_char(CH_DOT);
					2: add_char(punct[$urandom_range(0, 6)]);
					default: ;
				endcase
			end
			7: begin
				add_char(CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					c = ($urandom_range(0, 6) == 0) ? CH_LF : 8'($urandom_range(32, 126));
					if (c == CH_QUOTE)
						c = CH_SPACE;
					add_char(c);
				end
				// Now and then the string stays open and swallows what follows.
				if ($urandom_range(0, 7) != 0)
					add_char(CH_QUOTE);
			end
			8: begin
				add_char(CH_SLASH);
				add_char(CH_SLASH);
				repeat ($urandom_range(0, 6)) begin
					c = 8'($urandom_range(0, 255));
					add_char((c == CH_LF) ? CH_SPACE : c);
				end
				if ($urandom_range(0, 5) != 0)
					add_char(CH_LF);
			end
			9: add_char(punct[$urandom_range(0, 6)]);
			10: add_char(8'($urandom_range(0, 255)));
			default: begin
				case ($urandom_range(0, 3))
					0: add_char(8'h00);
					1: add_char(CH_UNDERSCORE);
					2: add_char(CH_DOT);
					default: add_char(8'($urandom_range(128, 255)));
				endcase
			end
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2: ;
			3, 4, 5: add_char(CH_LF);
			6, 7: add_char(8'($urandom_range(9, 13)));
			default: add_char(CH_SPACE);
		endcase
	endfunction

	initial begin : stimulus
		int random_sent;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed texts: every token kind, held dot and slash, final flushes.
		push_str("to=1.5{}+-*/x");
		send_text();
		push_str("3.=2.y//c\n_");
		add_char(8'hFF);
		add_char(8'h00);
		send_text();
		push_str("\"a\nb\"\"q");
		send_text();
		push_str("9.");
		send_text();
		push_str("/");
		send_text();
		wait_drained();

		// The receiver holds off while a burst of braces fills the block.
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (15) push_str("{}");
		send_text();
		no_gaps = 1'b0;
		wait_drained();

		random_sent = 0;
		while (random_sent < RANDOM_BYTES) begin
			repeat ($urandom_range(1, 16)) push_lexeme();
			random_sent += text_q.size();
			send_text();
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
